// ===== rtl/tmbe_pkg.sv =====
// Package for the tile mask boundary edge block: sizes, codes, state type,
// and the grid size clamp. Used by the top level and the side store RAM user.
`default_nettype none

package tmbe_pkg;

    localparam int MAX_DIM     = 64;
    localparam int CFG_W       = 7;
    localparam int CELL_W      = 6;
    localparam int RED_W       = 8;
    localparam int KIND_W      = 3;
    localparam int POS_W       = 7;
    localparam int SIGN_W      = 2;
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int MUL_W       = 2 * DIM_W;
    localparam int STORE_DEPTH = 2 * MAX_DIM * (MAX_DIM + 1);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DCNT_W      = $clog2(ADDR_W);
    localparam int SIDE_W      = 2;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TILE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HSIDE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_VSIDE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE  = 3'd4;

    localparam logic [SIDE_W-1:0] SIDE_EMPTY = 2'b00;
    localparam logic [SIDE_W-1:0] SIDE_POS   = 2'b01;
    localparam logic [SIDE_W-1:0] SIDE_NEG   = 2'b11;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_CLR      = 12'b0000_0000_0010,
        ST_MUL_WH   = 12'b0000_0000_0100,
        ST_MUL_ROW  = 12'b0000_0000_1000,
        ST_MUL_COL  = 12'b0000_0001_0000,
        ST_SETUP    = 12'b0000_0010_0000,
        ST_RD       = 12'b0000_0100_0000,
        ST_WR       = 12'b0000_1000_0000,
        ST_SCAN_RD  = 12'b0001_0000_0000,
        ST_SCAN_CHK = 12'b0010_0000_0000,
        ST_DIV      = 12'b0100_0000_0000,
        ST_EMIT     = 12'b1000_0000_0000
    } state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tile_mask_boundary_edges.sv =====
// Top level of the tile mask boundary edge block: sequencer, shared multiplier,
// serial divider and side store. Depends on tmbe_pkg and tmbe_ram.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+----------------------
//   in      | in_valid in_ready opcode cell_col         | item beat, one at a
//           | cell_row red_level                        | time
//   out     | out_valid out_ready kind pos_x pos_y      | one result beat per
//           | normal_sign                               | item, registered
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data    | register write beat
//
// Accept to result: load, three multiplier passes, an address step, four
// read-modify-writes and emit; drain, a multiplier pass, a read and a check
// per entry scanned, then the serial divider and emit on a hit or emit on done;
// other items, emit. Clear sweeps one store entry a cycle; so does reset, with
// in_ready low. in_ready is low while an item is at work; a finished item holds
// in its emit step while the result register is full.
`default_nettype none

module tile_mask_boundary_edges (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic        [1:0]                    opcode,
    input  wire logic        [tmbe_pkg::CELL_W-1:0]   cell_col,
    input  wire logic        [tmbe_pkg::CELL_W-1:0]   cell_row,
    input  wire logic        [tmbe_pkg::RED_W-1:0]    red_level,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic             [tmbe_pkg::KIND_W-1:0]   kind,
    output logic             [tmbe_pkg::POS_W-1:0]    pos_x,
    output logic             [tmbe_pkg::POS_W-1:0]    pos_y,
    output logic signed      [tmbe_pkg::SIGN_W-1:0]   normal_sign,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic                                 cfg_index,
    input  wire logic        [tmbe_pkg::CFG_W-1:0]    cfg_data
);

    tmbe_pkg::state_t state_reg, state_next;

    logic [tmbe_pkg::CFG_W-1:0]  grid_width_reg, grid_height_reg;
    logic [tmbe_pkg::DIM_W-1:0]  w_reg, h_reg, div_d_reg, rem_reg;
    logic [1:0]                  op_reg;
    logic [tmbe_pkg::CELL_W-1:0] col_reg, row_reg;
    logic [tmbe_pkg::ADDR_W-1:0] wh_reg, prod_reg, hidx_reg, vidx_reg, ptr_reg;
    logic [tmbe_pkg::ADDR_W-1:0] clr_cnt_reg, num_reg;
    logic [tmbe_pkg::DCNT_W-1:0] div_cnt_reg;
    logic [1:0]                  side_cnt_reg;
    logic                        clr_emit_reg;
    logic [tmbe_pkg::KIND_W-1:0] res_kind_reg;
    logic [tmbe_pkg::POS_W-1:0]  res_x_reg, res_y_reg;
    logic [tmbe_pkg::SIDE_W-1:0] res_sign_reg;
    logic                        out_valid_reg;
    logic [tmbe_pkg::KIND_W-1:0] out_kind_reg;
    logic [tmbe_pkg::POS_W-1:0]  out_x_reg, out_y_reg;
    logic [tmbe_pkg::SIDE_W-1:0] out_sign_reg;

    logic                        in_fire;
    logic [tmbe_pkg::DIM_W-1:0]  w_cfg, h_cfg;
    logic                        load_ok;
    logic [tmbe_pkg::DIM_W-1:0]  mul_a, mul_b;
    logic [tmbe_pkg::MUL_W-1:0]  mul_p;
    logic [tmbe_pkg::ADDR_W-1:0] horiz, total, side_addr;
    logic [tmbe_pkg::SIDE_W-1:0] side_code;
    logic                        ram_we;
    logic [tmbe_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [tmbe_pkg::SIDE_W-1:0] ram_wdata, ram_rdata;
    logic [tmbe_pkg::DIM_W:0]    div_shift;
    logic                        div_ge;
    logic [tmbe_pkg::DIM_W-1:0]  div_rem;
    logic [tmbe_pkg::POS_W-1:0]  emit_x, emit_y;
    logic                        out_free;

    tmbe_ram #(
        .WIDTH (tmbe_pkg::SIDE_W),
        .DEPTH (tmbe_pkg::STORE_DEPTH)
    ) u_side_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == tmbe_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    assign w_cfg   = tmbe_pkg::clamp_dim(grid_width_reg);
    assign h_cfg   = tmbe_pkg::clamp_dim(grid_height_reg);
    assign load_ok = (tmbe_pkg::DIM_W'(cell_col) < w_cfg)
                  && (tmbe_pkg::DIM_W'(cell_row) < h_cfg)
                  && (red_level == '0);

    always_comb
    begin
        mul_a = w_reg;
        mul_b = h_reg;
        unique case (state_reg)
            tmbe_pkg::ST_MUL_ROW:
            begin
                mul_a = w_reg;
                mul_b = tmbe_pkg::DIM_W'(row_reg);
            end
            tmbe_pkg::ST_MUL_COL:
            begin
                mul_a = h_reg;
                mul_b = tmbe_pkg::DIM_W'(col_reg);
            end
            default:
            begin
                mul_a = w_reg;
                mul_b = h_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign horiz = wh_reg + tmbe_pkg::ADDR_W'(w_reg);
    assign total = (wh_reg << 1) + tmbe_pkg::ADDR_W'(w_reg) + tmbe_pkg::ADDR_W'(h_reg);

    always_comb
    begin
        case (side_cnt_reg)
            2'd0:    side_addr = hidx_reg;
            2'd1:    side_addr = hidx_reg + tmbe_pkg::ADDR_W'(w_reg);
            2'd2:    side_addr = vidx_reg;
            default: side_addr = vidx_reg + tmbe_pkg::ADDR_W'(h_reg);
        endcase
    end

    assign side_code = side_cnt_reg[0] ? tmbe_pkg::SIDE_NEG : tmbe_pkg::SIDE_POS;

    assign div_shift = {rem_reg, num_reg[tmbe_pkg::ADDR_W-1]};
    assign div_ge    = (div_shift >= {1'b0, div_d_reg});
    assign div_rem   = div_ge ? tmbe_pkg::DIM_W'(div_shift - {1'b0, div_d_reg})
                              : tmbe_pkg::DIM_W'(div_shift);

    always_comb
    begin
        case (res_kind_reg)
            tmbe_pkg::KIND_HSIDE:
            begin
                emit_x = tmbe_pkg::POS_W'(rem_reg);
                emit_y = tmbe_pkg::POS_W'(num_reg);
            end
            tmbe_pkg::KIND_VSIDE:
            begin
                emit_x = tmbe_pkg::POS_W'(num_reg);
                emit_y = tmbe_pkg::POS_W'(rem_reg);
            end
            default:
            begin
                emit_x = res_x_reg;
                emit_y = res_y_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = clr_cnt_reg;
        ram_wdata  = tmbe_pkg::SIDE_EMPTY;
        ram_raddr  = side_addr;
        unique case (state_reg)
            tmbe_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (opcode)
                        tmbe_pkg::OP_CLEAR: state_next = tmbe_pkg::ST_CLR;
                        tmbe_pkg::OP_LOAD:
                            state_next = load_ok ? tmbe_pkg::ST_MUL_WH : tmbe_pkg::ST_EMIT;
                        tmbe_pkg::OP_DRAIN: state_next = tmbe_pkg::ST_MUL_WH;
                        default:            state_next = tmbe_pkg::ST_EMIT;
                    endcase
                end
            end
            tmbe_pkg::ST_CLR:
            begin
                ram_we = 1'b1;
                if (clr_cnt_reg == tmbe_pkg::ADDR_W'(tmbe_pkg::STORE_DEPTH - 1))
                begin
                    state_next = clr_emit_reg ? tmbe_pkg::ST_EMIT : tmbe_pkg::ST_IDLE;
                end
            end
            tmbe_pkg::ST_MUL_WH:
            begin
                state_next = (op_reg == tmbe_pkg::OP_LOAD) ? tmbe_pkg::ST_MUL_ROW
                                                           : tmbe_pkg::ST_SCAN_RD;
            end
            tmbe_pkg::ST_MUL_ROW: state_next = tmbe_pkg::ST_MUL_COL;
            tmbe_pkg::ST_MUL_COL: state_next = tmbe_pkg::ST_SETUP;
            tmbe_pkg::ST_SETUP:   state_next = tmbe_pkg::ST_RD;
            tmbe_pkg::ST_RD:      state_next = tmbe_pkg::ST_WR;
            tmbe_pkg::ST_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = side_addr;
                ram_wdata = (ram_rdata == tmbe_pkg::SIDE_EMPTY) ? side_code
                                                                : tmbe_pkg::SIDE_EMPTY;
                state_next = (side_cnt_reg == 2'd3) ? tmbe_pkg::ST_EMIT : tmbe_pkg::ST_RD;
            end
            tmbe_pkg::ST_SCAN_RD:
            begin
                ram_raddr  = ptr_reg;
                state_next = (ptr_reg >= total) ? tmbe_pkg::ST_EMIT : tmbe_pkg::ST_SCAN_CHK;
            end
            tmbe_pkg::ST_SCAN_CHK:
            begin
                state_next = (ram_rdata != tmbe_pkg::SIDE_EMPTY) ? tmbe_pkg::ST_DIV
                                                                 : tmbe_pkg::ST_SCAN_RD;
            end
            tmbe_pkg::ST_DIV:
            begin
                if (div_cnt_reg == tmbe_pkg::DCNT_W'(tmbe_pkg::ADDR_W - 1))
                begin
                    state_next = tmbe_pkg::ST_EMIT;
                end
            end
            tmbe_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = tmbe_pkg::ST_IDLE;
                end
            end
            default: state_next = tmbe_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tmbe_pkg::ST_CLR;
            grid_width_reg  <= tmbe_pkg::CFG_W'(64);
            grid_height_reg <= tmbe_pkg::CFG_W'(64);
            clr_cnt_reg     <= '0;
            clr_emit_reg    <= 1'b0;
            ptr_reg         <= '0;
            side_cnt_reg    <= '0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tmbe_pkg::CFG_IDX_WIDTH:  grid_width_reg  <= cfg_data;
                    tmbe_pkg::CFG_IDX_HEIGHT: grid_height_reg <= cfg_data;
                    default:                  grid_width_reg  <= grid_width_reg;
                endcase
            end

            if (state_reg == tmbe_pkg::ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                tmbe_pkg::ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        side_cnt_reg <= '0;
                        clr_cnt_reg  <= '0;
                        if (opcode == tmbe_pkg::OP_CLEAR)
                        begin
                            ptr_reg      <= '0;
                            clr_emit_reg <= 1'b1;
                        end
                    end
                end
                tmbe_pkg::ST_CLR:      clr_cnt_reg  <= clr_cnt_reg + 1'b1;
                tmbe_pkg::ST_WR:       side_cnt_reg <= side_cnt_reg + 1'b1;
                tmbe_pkg::ST_SCAN_RD:
                begin
                    if (ptr_reg >= total)
                    begin
                        ptr_reg <= total;
                    end
                end
                tmbe_pkg::ST_SCAN_CHK:
                begin
                    ptr_reg     <= ptr_reg + 1'b1;
                    div_cnt_reg <= '0;
                end
                tmbe_pkg::ST_DIV:      div_cnt_reg <= div_cnt_reg + 1'b1;
                default:               clr_emit_reg <= clr_emit_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            tmbe_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_reg       <= opcode;
                    col_reg      <= cell_col;
                    row_reg      <= cell_row;
                    w_reg        <= w_cfg;
                    h_reg        <= h_cfg;
                    res_kind_reg <= tmbe_pkg::KIND_NONE;
                    res_x_reg    <= '0;
                    res_y_reg    <= '0;
                    res_sign_reg <= '0;
                end
            end
            tmbe_pkg::ST_MUL_WH:  wh_reg <= tmbe_pkg::ADDR_W'(mul_p);
            tmbe_pkg::ST_MUL_ROW: prod_reg <= tmbe_pkg::ADDR_W'(mul_p);
            tmbe_pkg::ST_MUL_COL:
            begin
                hidx_reg <= prod_reg + tmbe_pkg::ADDR_W'(col_reg);
                prod_reg <= tmbe_pkg::ADDR_W'(mul_p);
            end
            tmbe_pkg::ST_SETUP:
            begin
                vidx_reg     <= horiz + prod_reg + tmbe_pkg::ADDR_W'(row_reg);
                res_kind_reg <= tmbe_pkg::KIND_TILE;
                res_x_reg    <= tmbe_pkg::POS_W'(col_reg);
                res_y_reg    <= tmbe_pkg::POS_W'(row_reg);
            end
            tmbe_pkg::ST_SCAN_RD:
            begin
                if (ptr_reg >= total)
                begin
                    res_kind_reg <= tmbe_pkg::KIND_DONE;
                end
            end
            tmbe_pkg::ST_SCAN_CHK:
            begin
                res_sign_reg <= ram_rdata;
                rem_reg      <= '0;
                if (ptr_reg < horiz)
                begin
                    num_reg      <= ptr_reg;
                    div_d_reg    <= w_reg;
                    res_kind_reg <= tmbe_pkg::KIND_HSIDE;
                end
                else
                begin
                    num_reg      <= ptr_reg - horiz;
                    div_d_reg    <= h_reg;
                    res_kind_reg <= tmbe_pkg::KIND_VSIDE;
                end
            end
            tmbe_pkg::ST_DIV:
            begin
                rem_reg <= div_rem;
                num_reg <= {num_reg[tmbe_pkg::ADDR_W-2:0], div_ge};
            end
            tmbe_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_kind_reg <= res_kind_reg;
                    out_x_reg    <= emit_x;
                    out_y_reg    <= emit_y;
                    out_sign_reg <= res_sign_reg;
                end
            end
            default:              wh_reg <= wh_reg;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign pos_x       = out_x_reg;
    assign pos_y       = out_y_reg;
    assign normal_sign = out_sign_reg;

    a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && opcode == tmbe_pkg::OP_CLEAR |=> state_reg == tmbe_pkg::ST_CLR)
        else $error("clear beat did not start the store sweep");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == tmbe_pkg::ST_WR || state_reg == tmbe_pkg::ST_CLR))
        else $error("side store written outside a write step");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= tmbe_pkg::ADDR_W'(tmbe_pkg::STORE_DEPTH))
        else $error("drain pointer beyond side store");

    a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == tmbe_pkg::KIND_DONE |-> pos_x == '0 && pos_y == '0
            && normal_sign == '0)
        else $error("done beat carries nonzero fields");

endmodule

`default_nettype wire

// ===== rtl/tmbe_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module tmbe_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8320
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== verif/tmbe_outline_monitor.sv =====
// Checker for the tile mask boundary edge block: watches the item, result and
// register channels, tracks its own side store and compares every result beat.
// Depends on tmbe_pkg.
module tmbe_outline_monitor (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_ready,
    input  wire logic        [1:0]                    opcode,
    input  wire logic        [tmbe_pkg::CELL_W-1:0]   cell_col,
    input  wire logic        [tmbe_pkg::CELL_W-1:0]   cell_row,
    input  wire logic        [tmbe_pkg::RED_W-1:0]    red_level,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire logic        [tmbe_pkg::KIND_W-1:0]   kind,
    input  wire logic        [tmbe_pkg::POS_W-1:0]    pos_x,
    input  wire logic        [tmbe_pkg::POS_W-1:0]    pos_y,
    input  wire logic signed [tmbe_pkg::SIGN_W-1:0]   normal_sign,
    input  wire logic                                 cfg_valid,
    input  wire logic                                 cfg_ready,
    input  wire logic                                 cfg_index,
    input  wire logic        [tmbe_pkg::CFG_W-1:0]    cfg_data,
    output int                                        fail_count,
    output int                                        awaited,
    output int                                        beats_checked,
    output logic                                      drain_end
);
    timeunit 1ns;
    timeprecision 1ps;

    import tmbe_pkg::*;

    typedef struct packed {
        logic        [KIND_W-1:0] kind;
        logic        [POS_W-1:0]  x;
        logic        [POS_W-1:0]  y;
        logic signed [SIGN_W-1:0] sign;
    } outline_beat_t;

    logic [SIDE_W-1:0] side_mem [STORE_DEPTH];
    int unsigned       scan_ptr;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    outline_beat_t     awaited_beats[$];
    outline_beat_t     want;
    outline_beat_t     got;
    int                misses;
    int                checked;

    function automatic int unsigned grid_dim(input logic [CFG_W-1:0] v);
        return (v == '0) ? 1 : ((int'(v) > MAX_DIM) ? MAX_DIM : int'(v));
    endfunction

    function automatic int unsigned side_count();
        int unsigned w;
        int unsigned h;
        w = grid_dim(width_reg);
        h = grid_dim(height_reg);
        return w * (h + 1) + h * (w + 1);
    endfunction

    function automatic void wipe_sides();
        for (int i = 0; i < STORE_DEPTH; i++)
            side_mem[i] = SIDE_EMPTY;
        scan_ptr = 0;
    endfunction

    function automatic void flip_side(input int unsigned idx, input logic [SIDE_W-1:0] code);
        if (idx < STORE_DEPTH)
            side_mem[idx] = (side_mem[idx] == SIDE_EMPTY) ? code : SIDE_EMPTY;
    endfunction

    function automatic void flag_fault(input string msg);
        misses++;
        if (misses <= 10)
            $display("%0t check: %s", $time, msg);
    endfunction

    function automatic outline_beat_t trace_outline(input logic [1:0] op,
                                                    input logic [CELL_W-1:0] col,
                                                    input logic [CELL_W-1:0] row,
                                                    input logic [RED_W-1:0] red);
        outline_beat_t r;
        int unsigned   w;
        int unsigned   h;
        int unsigned   horiz;
        int unsigned   total;
        int unsigned   p;
        int unsigned   k;
        w     = grid_dim(width_reg);
        h     = grid_dim(height_reg);
        horiz = w * (h + 1);
        total = horiz + h * (w + 1);
        r     = '0;
        case (op)
            OP_CLEAR:
                wipe_sides();
            OP_LOAD:
                if (col < w && row < h && red == '0)
                begin
                    flip_side(w * row + col, SIDE_POS);
                    flip_side(w * (row + 1) + col, SIDE_NEG);
                    flip_side(horiz + h * col + row, SIDE_POS);
                    flip_side(horiz + h * (col + 1) + row, SIDE_NEG);
                    r.kind = KIND_TILE;
                    r.x    = POS_W'(col);
                    r.y    = POS_W'(row);
                end
            OP_DRAIN:
            begin
                p = scan_ptr;
                while (p < total && side_mem[p] == SIDE_EMPTY)
                    p++;
                if (p < total)
                begin
                    r.sign = side_mem[p];
                    if (p < horiz)
                    begin
                        r.kind = KIND_HSIDE;
                        r.x    = POS_W'(p % w);
                        r.y    = POS_W'(p / w);
                    end
                    else
                    begin
                        k      = p - horiz;
                        r.kind = KIND_VSIDE;
                        r.x    = POS_W'(k / h);
                        r.y    = POS_W'(k % h);
                    end
                    scan_ptr = p + 1;
                end
                else
                begin
                    scan_ptr = total;
                    r.kind   = KIND_DONE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_sides();
            width_reg  = CFG_W'(64);
            height_reg = CFG_W'(64);
            awaited_beats.delete();
            misses  = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_IDX_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                got = {kind, pos_x, pos_y, normal_sign};
                if (awaited_beats.size() == 0)
                    flag_fault($sformatf("unexpected beat kind/x/y/sign %0d/%0d/%0d/%0d",
                                         got.kind, got.x, got.y, got.sign));
                else
                begin
                    want = awaited_beats.pop_front();
                    checked++;
                    if (got.kind !== want.kind || got.x !== want.x ||
                        got.y !== want.y || got.sign !== want.sign)
                        flag_fault($sformatf({"beat %0d kind/x/y/sign expected ",
                                              "%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d"},
                                             checked, want.kind, want.x, want.y, want.sign,
                                             got.kind, got.x, got.y, got.sign));
                end
            end
            if (in_valid && in_ready)
                awaited_beats = {awaited_beats,
                                 trace_outline(opcode, cell_col, cell_row, red_level)};
        end
        fail_count    <= misses;
        awaited       <= awaited_beats.size();
        beats_checked <= checked;
        drain_end     <= (scan_ptr >= side_count());
    end

endmodule

// ===== verif/tb.sv =====
// Top of the tile mask boundary edge testbench: clock, reset, item and register
// stimulus, result back-pressure and the verdict. Depends on tmbe_pkg, the block
// and tmbe_outline_monitor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmbe_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               opcode;
    logic [CELL_W-1:0]        cell_col;
    logic [CELL_W-1:0]        cell_row;
    logic [RED_W-1:0]         red_level;
    logic                     out_valid;
    logic                     out_ready;
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic signed [SIGN_W-1:0] normal_sign;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic                     cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    int                       fail_count;
    int                       awaited;
    int                       beats_checked;
    logic                     drain_end;

    int          hold_off_asks;
    int          served;
    int          rx_mode;
    int          rx_len;
    logic        rx_ready;
    int          sent_items;
    int          sent_loads;
    int          sent_drains;
    int          sent_clears;
    int          size_settings;
    int          burst_left;
    int          gap_max;
    int          ph;
    int          n;
    int          pick;
    int          col;
    int          row;
    int unsigned cols;
    int unsigned rows;
    int unsigned ox;
    int unsigned oy;
    logic [6:0]  w_set;
    logic [6:0]  h_set;
    logic [1:0]  noise_op;
    bit          keep_store;

    tile_mask_boundary_edges u_dut (.*);

    tmbe_outline_monitor u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // receiver: random stall pattern, plus a long hold-off whenever asked;
    // the hold-off outlasts a full store sweep so items pile up behind it
    initial
    begin
        out_ready = 1'b0;
        served    = 0;
        forever
        begin
            if (hold_off_asks != served)
            begin
                served = hold_off_asks;
                out_ready <= 1'b0;
                repeat (12000) @(posedge clk);
            end
            rx_mode = $urandom_range(0, 3);
            rx_len  = $urandom_range(10, 80);
            repeat (rx_len)
            begin
                case (rx_mode)
                    0:       rx_ready = 1'b1;
                    1:       rx_ready = $urandom_range(0, 1);
                    2:       rx_ready = ($urandom_range(0, 3) == 0);
                    default: rx_ready = ($urandom_range(0, 7) != 0);
                endcase
                out_ready <= rx_ready;
                @(posedge clk);
            end
        end
    end

    function automatic int unsigned cells_along(input logic [CFG_W-1:0] v);
        return (v == '0) ? 1 : ((int'(v) > MAX_DIM) ? MAX_DIM : int'(v));
    endfunction

    task automatic push_item(input logic [1:0] op, input int c, input int r, input int red);
        opcode    <= op;
        cell_col  <= CELL_W'(c);
        cell_row  <= CELL_W'(r);
        red_level <= RED_W'(red);
        in_valid  <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sent_items++;
        case (op)
            OP_LOAD:  sent_loads++;
            OP_DRAIN: sent_drains++;
            OP_CLEAR: sent_clears++;
            default:  ;
        endcase
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            if (gap_max > 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_grid(input logic [6:0] w, input logic [6:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_WIDTH;
        cfg_data  <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_IDX_HEIGHT;
        cfg_data  <= h;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_settings++;
        cols = cells_along(w);
        rows = cells_along(h);
    endtask

    // drain until the outline is exhausted; ends on a done beat or on a hit at the last side
    task automatic drain_all();
        do
            push_item(OP_DRAIN, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 255));
        while (!drain_end);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_CLEAR;
        cell_col      = '0;
        cell_row      = '0;
        red_level     = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_IDX_WIDTH;
        cfg_data      = '0;
        hold_off_asks = 0;
        sent_items    = 0;
        sent_loads    = 0;
        sent_drains   = 0;
        sent_clears   = 0;
        size_settings = 0;
        burst_left    = 0;
        gap_max       = 2;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_grid(7'd3, 7'd2);
        push_item(OP_CLEAR, 0, 0, 0);
        push_item(OP_LOAD, 0, 0, 0);
        push_item(OP_LOAD, 1, 0, 0);
        push_item(OP_LOAD, 2, 1, 0);
        push_item(OP_LOAD, 1, 1, 255);
        push_item(OP_LOAD, 3, 0, 0);
        push_item(OP_LOAD, 0, 2, 0);
        push_item(OP_LOAD, 63, 63, 0);
        push_item(OP_SPARE, 63, 63, 255);
        push_item(OP_LOAD, 2, 1, 0);
        push_item(OP_LOAD, 2, 1, 0);
        drain_all();
        // side toggled behind the exhausted pointer stays hidden
        push_item(OP_LOAD, 0, 0, 0);
        push_item(OP_DRAIN, 63, 63, 255);
        settle();

        for (ph = 0; sent_items < 540; ph++)
        begin
            case (ph)
                0:       {w_set, h_set} = {7'd1, 7'd1};
                1:       {w_set, h_set} = {7'd0, 7'd0};
                2:       {w_set, h_set} = {7'd64, 7'd64};
                3:       {w_set, h_set} = {7'd127, 7'd127};
                4:       {w_set, h_set} = {7'd1, 7'd64};
                5:       {w_set, h_set} = {7'd127, 7'd2};
                default:
                    if ($urandom_range(0, 19) < 17)
                        {w_set, h_set} = {7'($urandom_range(2, 8)), 7'($urandom_range(2, 8))};
                    else
                        {w_set, h_set} = {7'($urandom_range(0, 127)),
                                          7'($urandom_range(0, 127))};
            endcase
            keep_store = (ph > 0 && $urandom_range(0, 4) == 0);
            gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            write_grid(w_set, h_set);
            if (!keep_store)
                push_item(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 255));
            if (ph == 2)
                hold_off_asks++;
            ox = $urandom_range(0, cols - 1);
            oy = $urandom_range(0, rows - 1);
            n  = $urandom_range(10, 22);
            repeat (n)
            begin
                pick = $urandom_range(0, 99);
                col  = ox + $urandom_range(0, 4);
                row  = oy + $urandom_range(0, 4);
                if (col >= cols)
                    col = cols - 1;
                if (row >= rows)
                    row = rows - 1;
                if (pick < 70)
                    push_item(OP_LOAD, col, row,
                              ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : 0);
                else if (pick < 82)
                    push_item(OP_DRAIN, $urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 255));
                else if (pick < 86)
                    settle();
                else if (pick < 88)
                    push_item(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 255));
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       noise_op = OP_LOAD;
                        1:       noise_op = OP_SPARE;
                        default: noise_op = OP_DRAIN;
                    endcase
                    push_item(noise_op, $urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 1) ? 0 : $urandom_range(0, 255));
                end
            end
            drain_all();
            settle();
        end

        repeat (40) @(posedge clk);
        $display("tb: %0d items (%0d loads, %0d drains, %0d clears) over %0d grid sizes",
                 sent_items, sent_loads, sent_drains, sent_clears, size_settings);
        $display("tb: %0d result beats compared, %0d still awaited", beats_checked, awaited);
        if (fail_count == 0 && awaited == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
